// ----- rtl/assert_macros.svh -----
// Assertion macros used by the RTL back end (cft_back).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define CFT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication
`define CFT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/cft_pkg.sv -----
// Package: shared types, constants and codes of the connection-tracking firewall.
package cft_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;

  localparam logic [15:0] ETYPE_VLAN_C = 16'h8100;
  localparam logic [15:0] ETYPE_VLAN_S = 16'h88A8;
  localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
  localparam logic [7:0]  PROTO_TCP    = 8'd6;

  localparam logic [15:0] HDR_LEN_PLAIN  = 16'd54;
  localparam logic [15:0] HDR_LEN_TAGGED = 16'd58;

  localparam logic [63:0] IDLE_TIMEOUT_RST = 64'd60000000000;

  localparam logic [2:0] ST_SYN_SENT  = 3'd0;
  localparam logic [2:0] ST_SYN_RECV  = 3'd1;
  localparam logic [2:0] ST_ESTAB     = 3'd2;
  localparam logic [2:0] ST_FIN_WAIT1 = 3'd3;
  localparam logic [2:0] ST_FIN_WAIT2 = 3'd4;
  localparam logic [2:0] ST_TIME_WAIT = 3'd5;
  localparam logic [2:0] ST_NONE      = 3'd6;

  localparam logic [3:0] R_UNTRACKED = 4'd0;
  localparam logic [3:0] R_NEW       = 4'd1;
  localparam logic [3:0] R_FULL      = 4'd2;
  localparam logic [3:0] R_NOT_SYN   = 4'd3;
  localparam logic [3:0] R_TIMEOUT   = 4'd4;
  localparam logic [3:0] R_ACCEPT    = 4'd5;
  localparam logic [3:0] R_RST       = 4'd6;
  localparam logic [3:0] R_FINAL     = 4'd7;
  localparam logic [3:0] R_BAD       = 4'd8;

  typedef struct packed {
    logic [31:0] ip_hi;
    logic [31:0] ip_lo;
    logic [15:0] port_hi;
    logic [15:0] port_lo;
  } key_t;

  typedef struct packed {
    logic        untracked;
    key_t        key;
    logic [4:0]  flags;
    logic [63:0] now;
  } req_t;

  typedef struct packed {
    key_t        key;
    logic [2:0]  st;
    logic [63:0] last;
  } ent_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_CMP,
    BK_EXEC
  } bk_state_t;

endpackage

// ----- rtl/cft_queue.sv -----
// Two-entry request queue between the classifier and the table engine.
module cft_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cft_pkg::req_t wr_data,
  output logic          full,
  input  logic          pop,
  output logic          rd_valid,
  output cft_pkg::req_t rd_data
);

  cft_pkg::req_t mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign full     = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && rd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- rtl/cft_front.sv -----
// Front end: classify a header record, build the normalized key, queue the request.
module cft_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  logic [15:0]   in_outer_ethertype,
  input  logic [15:0]   in_inner_ethertype,
  input  logic [15:0]   in_frame_length,
  input  logic [7:0]    in_ip_protocol,
  input  logic [31:0]   in_source_address,
  input  logic [31:0]   in_destination_address,
  input  logic [15:0]   in_source_port,
  input  logic [15:0]   in_destination_port,
  input  logic [4:0]    in_tcp_flags,
  input  logic [63:0]   in_timestamp,
  input  logic          req_pop,
  output logic          req_valid,
  output cft_pkg::req_t req
);

  cft_pkg::req_t cls;
  logic          vlan;
  logic [15:0]   etype;
  logic [15:0]   need;
  logic          sa_gt;
  logic          sp_gt;

  always_comb begin
    vlan   = (in_outer_ethertype == cft_pkg::ETYPE_VLAN_C) ||
             (in_outer_ethertype == cft_pkg::ETYPE_VLAN_S);
    etype  = vlan ? in_inner_ethertype : in_outer_ethertype;
    need   = vlan ? cft_pkg::HDR_LEN_TAGGED : cft_pkg::HDR_LEN_PLAIN;
    sa_gt  = in_source_address > in_destination_address;
    sp_gt  = in_source_port > in_destination_port;
    cls.untracked   = (etype != cft_pkg::ETYPE_IPV4) ||
                      (in_ip_protocol != cft_pkg::PROTO_TCP) ||
                      (in_frame_length < need);
    cls.key.ip_hi   = sa_gt ? in_source_address : in_destination_address;
    cls.key.ip_lo   = sa_gt ? in_destination_address : in_source_address;
    cls.key.port_hi = sp_gt ? in_source_port : in_destination_port;
    cls.key.port_lo = sp_gt ? in_destination_port : in_source_port;
    cls.flags       = in_tcp_flags;
    cls.now         = in_timestamp;
  end

  cft_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_push),
    .wr_data  (cls),
    .full     (in_full),
    .pop      (req_pop),
    .rd_valid (req_valid),
    .rd_data  (req)
  );

endmodule

// ----- rtl/cft_back.sv -----
// Back end: scan the connection table, step the TCP state, hold the verdict.
`include "assert_macros.svh"
module cft_back #(
  parameter int TABLE_ENTRIES = cft_pkg::TABLE_ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          req_valid,
  input  cft_pkg::req_t req,
  output logic          req_pop,
  input  logic          cfg_we,
  input  logic [63:0]   cfg_data,
  output logic          out_empty,
  input  logic          out_pop,
  output logic          out_verdict,
  output logic [3:0]    out_reason,
  output logic [2:0]    out_connection_state
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

  cft_pkg::ent_t mem [TABLE_ENTRIES];
  cft_pkg::ent_t rdata_r;

  cft_pkg::bk_state_t state_r, state_nxt;
  cft_pkg::req_t      req_r;
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [IW-1:0] idx_r;
  logic [IW-1:0] hit_idx_r;
  logic [IW-1:0] free_idx_r;
  logic          hit_r;
  logic          free_r;
  logic [2:0]    st_r;
  logic [63:0]   last_r;
  logic [63:0]   timeout_r;

  logic          out_valid_r;
  logic          out_verdict_r;
  logic [3:0]    out_reason_r;
  logic [2:0]    out_state_r;

  logic          start;
  logic          match;
  logic          res_we;
  logic          res_verdict;
  logic [3:0]    res_reason;
  logic [2:0]    res_state;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [2:0]    mem_st;
  logic          vset;
  logic          vclr;
  logic          expired;
  logic          ok;
  logic [2:0]    nst;
  logic          fin, syn, rst, psh, ack;

  assign out_empty            = !out_valid_r;
  assign out_verdict          = out_verdict_r;
  assign out_reason           = out_reason_r;
  assign out_connection_state = out_state_r;

  assign start   = (state_r == cft_pkg::BK_IDLE) && req_valid && !out_valid_r;
  assign req_pop = start;
  assign match   = valid_r[idx_r] && (rdata_r.key == req_r.key);
  assign fin     = req_r.flags[0];
  assign syn     = req_r.flags[1];
  assign rst     = req_r.flags[2];
  assign psh     = req_r.flags[3];
  assign ack     = req_r.flags[4];
  assign expired = (req_r.now - last_r) > timeout_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= '{key: req_r.key, st: mem_st, last: req_r.now};
    end
    rdata_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cft_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    res_we      = 1'b0;
    res_verdict = 1'b0;
    res_reason  = cft_pkg::R_UNTRACKED;
    res_state   = cft_pkg::ST_NONE;
    mem_we      = 1'b0;
    mem_wa      = hit_idx_r;
    mem_st      = cft_pkg::ST_SYN_RECV;
    vset        = 1'b0;
    vclr        = 1'b0;
    ok          = 1'b0;
    nst         = st_r;
    case (state_r)
      cft_pkg::BK_IDLE: begin
        if (start) begin
          if (req.untracked) begin
            res_we = 1'b1;
          end else begin
            state_nxt = cft_pkg::BK_READ;
          end
        end
      end
      cft_pkg::BK_READ: begin
        state_nxt = cft_pkg::BK_CMP;
      end
      cft_pkg::BK_CMP: begin
        if (match || idx_r == LAST_IDX) begin
          state_nxt = cft_pkg::BK_EXEC;
        end else begin
          state_nxt = cft_pkg::BK_READ;
        end
      end
      cft_pkg::BK_EXEC: begin
        state_nxt = cft_pkg::BK_IDLE;
        res_we    = 1'b1;
        if (!hit_r) begin
          if (!(syn && !ack)) begin
            res_verdict = 1'b1;
            res_reason  = cft_pkg::R_NOT_SYN;
          end else if (!free_r) begin
            res_reason = cft_pkg::R_FULL;
          end else begin
            mem_we     = 1'b1;
            mem_wa     = free_idx_r;
            vset       = 1'b1;
            res_reason = cft_pkg::R_NEW;
            res_state  = cft_pkg::ST_SYN_RECV;
          end
        end else if (expired) begin
          vclr        = 1'b1;
          res_verdict = 1'b1;
          res_reason  = cft_pkg::R_TIMEOUT;
        end else begin
          case (st_r)
            cft_pkg::ST_SYN_SENT: begin
              if (!syn && ack) begin
                nst = cft_pkg::ST_ESTAB;
                ok  = 1'b1;
              end else if (syn && ack) begin
                nst = cft_pkg::ST_SYN_RECV;
                ok  = 1'b1;
              end else if (rst) begin
                vclr       = 1'b1;
                res_reason = cft_pkg::R_RST;
              end
            end
            cft_pkg::ST_SYN_RECV: begin
              if (ack && !syn) begin
                nst = cft_pkg::ST_ESTAB;
                ok  = 1'b1;
              end
            end
            cft_pkg::ST_ESTAB: begin
              if (fin) begin
                nst = cft_pkg::ST_FIN_WAIT1;
                ok  = 1'b1;
              end else if (rst) begin
                vclr        = 1'b1;
                res_verdict = 1'b1;
                res_reason  = cft_pkg::R_RST;
              end else if (ack) begin
                ok = 1'b1;
              end
            end
            cft_pkg::ST_FIN_WAIT1: begin
              if (ack) begin
                nst = cft_pkg::ST_FIN_WAIT2;
                ok  = 1'b1;
              end
            end
            cft_pkg::ST_FIN_WAIT2: begin
              if (fin) begin
                nst = cft_pkg::ST_TIME_WAIT;
                ok  = 1'b1;
              end else if (ack || psh) begin
                ok = 1'b1;
              end
            end
            cft_pkg::ST_TIME_WAIT: begin
              if (ack) begin
                vclr       = 1'b1;
                res_reason = cft_pkg::R_FINAL;
              end
            end
            default: begin
              ok = 1'b0;
            end
          endcase
          if (!vclr) begin
            if (ok) begin
              mem_we     = 1'b1;
              mem_st     = nst;
              res_reason = cft_pkg::R_ACCEPT;
              res_state  = nst;
            end else begin
              res_verdict = 1'b1;
              res_reason  = cft_pkg::R_BAD;
              res_state   = st_r;
            end
          end
        end
      end
      default: begin
        state_nxt = cft_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) begin
      req_r <= req;
    end
    case (state_r)
      cft_pkg::BK_IDLE: begin
        idx_r <= '0;
      end
      cft_pkg::BK_CMP: begin
        if (match) begin
          hit_idx_r <= idx_r;
          st_r      <= rdata_r.st;
          last_r    <= rdata_r.last;
        end else if (idx_r != LAST_IDX) begin
          idx_r <= idx_r + IW'(1);
        end
        if (!valid_r[idx_r] && !free_r) begin
          free_idx_r <= idx_r;
        end
      end
      default: begin
        idx_r <= idx_r;
      end
    endcase
    if (res_we) begin
      out_verdict_r <= res_verdict;
      out_reason_r  <= res_reason;
      out_state_r   <= res_state;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      out_valid_r <= 1'b0;
      timeout_r   <= cft_pkg::IDLE_TIMEOUT_RST;
    end else begin
      if (cfg_we) timeout_r <= cfg_data;
      if (start) begin
        hit_r  <= 1'b0;
        free_r <= 1'b0;
      end else if (state_r == cft_pkg::BK_CMP) begin
        if (match) hit_r <= 1'b1;
        if (!valid_r[idx_r]) free_r <= 1'b1;
      end
      if (vset) valid_r[free_idx_r] <= 1'b1;
      if (vclr) valid_r[hit_idx_r]  <= 1'b0;
      if (res_we) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `CFT_ASSERT_IMP(a_no_overwrite, res_we, !out_valid_r)
  `CFT_ASSERT_IMP(a_write_in_exec, mem_we || vclr, state_r == cft_pkg::BK_EXEC)
  `CFT_ASSERT_NXT(a_read_then_cmp, state_r == cft_pkg::BK_READ, state_r == cft_pkg::BK_CMP)
  `CFT_ASSERT_IMP(a_hit_stops_scan, state_r == cft_pkg::BK_EXEC && hit_r, valid_r[hit_idx_r])

endmodule

// ----- rtl/tcp_conntrack_firewall_top.sv -----
// Untracked frame: the verdict is registered directly from the idle state. Tracked frame:
// table scan, each slot through a read state and a compare state, stopping at the match or
// the last slot, then the step state (EXEC) registers the verdict. One request is worked
// at a time; a 2-entry queue takes further requests meanwhile. The table read port sets the
// rate. Reset (rst_n low, synchronous) clears all slot valid bits, the request queue and the
// held verdict at once and reloads the idle timeout; no clearing pass.
module tcp_conntrack_firewall_top #(
  parameter int TABLE_ENTRIES = cft_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [15:0] in_outer_ethertype,
  input  logic [15:0] in_inner_ethertype,
  input  logic [15:0] in_frame_length,
  input  logic [7:0]  in_ip_protocol,
  input  logic [31:0] in_source_address,
  input  logic [31:0] in_destination_address,
  input  logic [15:0] in_source_port,
  input  logic [15:0] in_destination_port,
  input  logic [4:0]  in_tcp_flags,
  input  logic [63:0] in_timestamp,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_verdict,
  output logic [3:0]  out_reason,
  output logic [2:0]  out_connection_state,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data
);

  cft_pkg::req_t req;
  logic          req_valid;
  logic          req_pop;

  assign cfg_ready = 1'b1;

  cft_front u_front (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_push                (in_push),
    .in_full                (in_full),
    .in_outer_ethertype     (in_outer_ethertype),
    .in_inner_ethertype     (in_inner_ethertype),
    .in_frame_length        (in_frame_length),
    .in_ip_protocol         (in_ip_protocol),
    .in_source_address      (in_source_address),
    .in_destination_address (in_destination_address),
    .in_source_port         (in_source_port),
    .in_destination_port    (in_destination_port),
    .in_tcp_flags           (in_tcp_flags),
    .in_timestamp           (in_timestamp),
    .req_pop                (req_pop),
    .req_valid              (req_valid),
    .req                    (req)
  );

  cft_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .req_valid            (req_valid),
    .req                  (req),
    .req_pop              (req_pop),
    .cfg_we               (cfg_valid && cfg_ready),
    .cfg_data             (cfg_data),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_verdict          (out_verdict),
    .out_reason           (out_reason),
    .out_connection_state (out_connection_state)
  );

endmodule

// ----- tb/conntrack_checker.sv -----
// Checker for the connection-tracking firewall: predicts each verdict and compares it.
module conntrack_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [15:0] in_outer_ethertype,
  input  logic [15:0] in_inner_ethertype,
  input  logic [15:0] in_frame_length,
  input  logic [7:0]  in_ip_protocol,
  input  logic [31:0] in_source_address,
  input  logic [31:0] in_destination_address,
  input  logic [15:0] in_source_port,
  input  logic [15:0] in_destination_port,
  input  logic [4:0]  in_tcp_flags,
  input  logic [63:0] in_timestamp,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic        out_verdict,
  input  logic [3:0]  out_reason,
  input  logic [2:0]  out_connection_state,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [63:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          checked
);

  localparam int SLOTS = cft_pkg::TABLE_ENTRIES_DEF;
  localparam logic [4:0] FL_FIN = 5'h01;
  localparam logic [4:0] FL_SYN = 5'h02;
  localparam logic [4:0] FL_RST = 5'h04;
  localparam logic [4:0] FL_PSH = 5'h08;
  localparam logic [4:0] FL_ACK = 5'h10;

  typedef struct packed {
    logic       verdict;
    logic [3:0] reason;
    logic [2:0] st;
  } verdict_t;

  logic          conn_valid [SLOTS];
  cft_pkg::key_t tbl_key [SLOTS];
  logic [2:0]    conn_st [SLOTS];
  logic [63:0]   conn_last [SLOTS];
  logic [63:0]   idle_limit;
  verdict_t      verdict_q[$];

  function automatic verdict_t mk(logic v, logic [3:0] r, logic [2:0] s);
    verdict_t t;
    t.verdict = v;
    t.reason = r;
    t.st = s;
    return t;
  endfunction

  function automatic verdict_t judge_packet(logic [15:0] outer, logic [15:0] inner,
      logic [15:0] flen, logic [7:0] proto, logic [31:0] sa, logic [31:0] da,
      logic [15:0] sp, logic [15:0] dp, logic [4:0] fl, logic [63:0] now);
    logic vlan;
    logic [15:0] etype;
    logic [15:0] need;
    cft_pkg::key_t k;
    int hit;
    int free_slot;
    logic [2:0] st;
    vlan = (outer == cft_pkg::ETYPE_VLAN_C) || (outer == cft_pkg::ETYPE_VLAN_S);
    etype = vlan ? inner : outer;
    need = vlan ? cft_pkg::HDR_LEN_TAGGED : cft_pkg::HDR_LEN_PLAIN;
    if (etype != cft_pkg::ETYPE_IPV4 || proto != cft_pkg::PROTO_TCP || flen < need)
      return mk(1'b0, cft_pkg::R_UNTRACKED, cft_pkg::ST_NONE);
    k.ip_hi = (sa > da) ? sa : da;
    k.ip_lo = (sa > da) ? da : sa;
    k.port_hi = (sp > dp) ? sp : dp;
    k.port_lo = (sp > dp) ? dp : sp;
    hit = -1;
    free_slot = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (conn_valid[i]) begin
        if (hit < 0 && tbl_key[i] == k) hit = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (hit < 0) begin
      if (!((fl & FL_SYN) != 0 && (fl & FL_ACK) == 0))
        return mk(1'b1, cft_pkg::R_NOT_SYN, cft_pkg::ST_NONE);
      if (free_slot < 0) return mk(1'b0, cft_pkg::R_FULL, cft_pkg::ST_NONE);
      conn_valid[free_slot] = 1'b1;
      tbl_key[free_slot] = k;
      conn_st[free_slot] = cft_pkg::ST_SYN_RECV;
      conn_last[free_slot] = now;
      return mk(1'b0, cft_pkg::R_NEW, cft_pkg::ST_SYN_RECV);
    end
    if (now - conn_last[hit] > idle_limit) begin
      conn_valid[hit] = 1'b0;
      return mk(1'b1, cft_pkg::R_TIMEOUT, cft_pkg::ST_NONE);
    end
    st = conn_st[hit];
    case (st)
      cft_pkg::ST_SYN_SENT: begin
        if ((fl & FL_SYN) == 0 && (fl & FL_ACK) != 0) st = cft_pkg::ST_ESTAB;
        else if ((fl & FL_SYN) != 0 && (fl & FL_ACK) != 0) st = cft_pkg::ST_SYN_RECV;
        else if ((fl & FL_RST) != 0) begin
          conn_valid[hit] = 1'b0;
          return mk(1'b0, cft_pkg::R_RST, cft_pkg::ST_NONE);
        end else return mk(1'b1, cft_pkg::R_BAD, conn_st[hit]);
      end
      cft_pkg::ST_SYN_RECV: begin
        if ((fl & FL_ACK) != 0 && (fl & FL_SYN) == 0) st = cft_pkg::ST_ESTAB;
        else return mk(1'b1, cft_pkg::R_BAD, st);
      end
      cft_pkg::ST_ESTAB: begin
        if ((fl & FL_FIN) != 0) st = cft_pkg::ST_FIN_WAIT1;
        else if ((fl & FL_RST) != 0) begin
          conn_valid[hit] = 1'b0;
          return mk(1'b1, cft_pkg::R_RST, cft_pkg::ST_NONE);
        end else if ((fl & FL_ACK) == 0) return mk(1'b1, cft_pkg::R_BAD, st);
      end
      cft_pkg::ST_FIN_WAIT1: begin
        if ((fl & FL_ACK) != 0) st = cft_pkg::ST_FIN_WAIT2;
        else return mk(1'b1, cft_pkg::R_BAD, st);
      end
      cft_pkg::ST_FIN_WAIT2: begin
        if ((fl & FL_FIN) != 0) st = cft_pkg::ST_TIME_WAIT;
        else if ((fl & (FL_ACK | FL_PSH)) == 0) return mk(1'b1, cft_pkg::R_BAD, st);
      end
      cft_pkg::ST_TIME_WAIT: begin
        if ((fl & FL_ACK) != 0) begin
          conn_valid[hit] = 1'b0;
          return mk(1'b0, cft_pkg::R_FINAL, cft_pkg::ST_NONE);
        end
        return mk(1'b1, cft_pkg::R_BAD, st);
      end
      default: return mk(1'b1, cft_pkg::R_BAD, st);
    endcase
    conn_st[hit] = st;
    conn_last[hit] = now;
    return mk(1'b0, cft_pkg::R_ACCEPT, st);
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      idle_limit = cft_pkg::IDLE_TIMEOUT_RST;
      for (int i = 0; i < SLOTS; i++) conn_valid[i] = 1'b0;
      verdict_q.delete();
      fail_count = 0;
      checked = 0;
    end else begin
      if (cfg_valid && cfg_ready) idle_limit = cfg_data;
      if (in_push && !in_full)
        verdict_q.push_back(judge_packet(in_outer_ethertype, in_inner_ethertype,
          in_frame_length, in_ip_protocol, in_source_address, in_destination_address,
          in_source_port, in_destination_port, in_tcp_flags, in_timestamp));
      if (out_pop && !out_empty) begin
        checked++;
        if (verdict_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected verdict %0d reason %0d state %0d", out_verdict,
                     out_reason, out_connection_state);
        end else begin
          want = verdict_q.pop_front();
          if (want.verdict !== out_verdict || want.reason !== out_reason ||
              want.st !== out_connection_state) begin
            fail_count++;
            if (fail_count <= 10)
              $display("verdict mismatch #%0d: exp v%0d r%0d s%0d got v%0d r%0d s%0d",
                       checked, want.verdict, want.reason, want.st, out_verdict,
                       out_reason, out_connection_state);
          end
        end
      end
    end
    pending = verdict_q.size();
  end
endmodule

// ----- tb/tb_top.sv -----
// Testbench top: drives packets and timeout settings into the firewall and reports.
module tb_top;

  localparam int NFLOW = 80;
  localparam int DRAIN = 2 * cft_pkg::TABLE_ENTRIES_DEF + 10;
  localparam int STALL_LIMIT = 5000;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [15:0] in_outer_ethertype;
  logic [15:0] in_inner_ethertype;
  logic [15:0] in_frame_length;
  logic [7:0]  in_ip_protocol;
  logic [31:0] in_source_address;
  logic [31:0] in_destination_address;
  logic [15:0] in_source_port;
  logic [15:0] in_destination_port;
  logic [4:0]  in_tcp_flags;
  logic [63:0] in_timestamp;
  logic        out_empty;
  logic        out_pop;
  logic        out_verdict;
  logic [3:0]  out_reason;
  logic [2:0]  out_connection_state;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [63:0] cfg_data;
  int          fail_count;
  int          pending;
  int          checked;

  logic        quiet;
  logic        hold_req;
  logic        hold_taken;
  int          stall_cycles;
  int          packets_sent;
  int          settings_used;
  logic [63:0] now;
  logic [31:0] flow_sa [NFLOW];
  logic [31:0] flow_da [NFLOW];
  logic [15:0] flow_sp [NFLOW];
  logic [15:0] flow_dp [NFLOW];
  int          flow_step [NFLOW];
  logic [4:0]  close_seq [7] = '{5'h02, 5'h10, 5'h18, 5'h01, 5'h10, 5'h01, 5'h10};

  tcp_conntrack_firewall_top dut (.*);

  conntrack_checker u_checker (.*);

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("[tcp_conntrack_firewall_top] ERROR");
      $finish;
    end
  end

  initial begin
    hold_taken = 1'b0;
    out_pop <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !hold_taken) begin
        out_pop <= 1'b0;
        repeat (300) @(posedge clk);
        hold_taken = 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_pkt(logic [15:0] outer, logic [15:0] inner, logic [15:0] flen,
      logic [7:0] proto, logic [31:0] sa, logic [31:0] da, logic [15:0] sp,
      logic [15:0] dp, logic [4:0] fl, logic [63:0] ts);
    in_push <= 1'b1;
    in_outer_ethertype <= outer;
    in_inner_ethertype <= inner;
    in_frame_length <= flen;
    in_ip_protocol <= proto;
    in_source_address <= sa;
    in_destination_address <= da;
    in_source_port <= sp;
    in_destination_port <= dp;
    in_tcp_flags <= fl;
    in_timestamp <= ts;
    do @(posedge clk); while (in_full);
    packets_sent++;
  endtask

  task automatic send_tcp(logic [31:0] sa, logic [31:0] da, logic [15:0] sp,
      logic [15:0] dp, logic [4:0] fl);
    logic [15:0] outer;
    logic [15:0] flen;
    case ($urandom_range(0, 3))
      0: outer = cft_pkg::ETYPE_VLAN_C;
      1: outer = cft_pkg::ETYPE_VLAN_S;
      default: outer = cft_pkg::ETYPE_IPV4;
    endcase
    flen = (outer == cft_pkg::ETYPE_IPV4) ? cft_pkg::HDR_LEN_PLAIN : cft_pkg::HDR_LEN_TAGGED;
    if ($urandom_range(0, 2) != 0) flen = 16'($urandom_range(flen, 16'hFFFF));
    send_pkt(outer, cft_pkg::ETYPE_IPV4, flen, cft_pkg::PROTO_TCP, sa, da, sp, dp, fl, now);
  endtask

  task automatic pause_sender(int n);
    in_push <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic set_timeout(logic [63:0] v);
    in_push <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic new_flows();
    for (int f = 0; f < NFLOW; f++) begin
      flow_sa[f] = (f % 9 == 0) ? 32'h0A000001 : $urandom;
      flow_da[f] = (f % 11 == 0) ? flow_sa[f] : $urandom;
      flow_sp[f] = (f % 7 == 0) ? 16'd80 : 16'($urandom);
      flow_dp[f] = (f % 13 == 0) ? flow_sp[f] : 16'($urandom);
      flow_step[f] = 0;
    end
  endtask

  task automatic run_traffic(int count, int tick_max);
    int f;
    int r;
    logic [4:0] fl;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 49) == 0) now = {$urandom, $urandom};
      else now = now + 64'($urandom_range(0, tick_max));
      if (r < 8) begin
        send_pkt(16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom), $urandom,
                 $urandom, 16'($urandom), 16'($urandom), 5'($urandom),
                 {$urandom, $urandom});
      end else if (r < 12) begin
        send_tcp($urandom, $urandom, 16'($urandom), 16'($urandom), 5'($urandom));
      end else begin
        f = $urandom_range(0, NFLOW - 1);
        fl = ($urandom_range(0, 4) == 0) ? 5'($urandom) : close_seq[flow_step[f]];
        flow_step[f] = (flow_step[f] + 1) % 7;
        if ($urandom_range(0, 1) == 0)
          send_tcp(flow_sa[f], flow_da[f], flow_sp[f], flow_dp[f], fl);
        else
          send_tcp(flow_da[f], flow_sa[f], flow_dp[f], flow_sp[f], fl);
      end
      if (!quiet && $urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 12));
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    quiet = 1'b0;
    hold_req = 1'b0;
    packets_sent = 0;
    settings_used = 1;
    now = 64'd1000;
    in_push <= 1'b0;
    in_outer_ethertype <= '0;
    in_inner_ethertype <= '0;
    in_frame_length <= '0;
    in_ip_protocol <= '0;
    in_source_address <= '0;
    in_destination_address <= '0;
    in_source_port <= '0;
    in_destination_port <= '0;
    in_tcp_flags <= '0;
    in_timestamp <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // untracked frames: wrong type, wrong protocol, one byte short
    send_pkt(16'h86DD, cft_pkg::ETYPE_IPV4, 16'hFFFF, cft_pkg::PROTO_TCP, 32'd1, 32'd2,
             16'd3, 16'd4, 5'h02, now);
    send_pkt(cft_pkg::ETYPE_IPV4, 16'h0, 16'hFFFF, 8'd17, 32'd1, 32'd2, 16'd3, 16'd4,
             5'h02, now);
    send_pkt(cft_pkg::ETYPE_IPV4, 16'h0, 16'(cft_pkg::HDR_LEN_PLAIN - 16'd1),
             cft_pkg::PROTO_TCP, 32'd1, 32'd2, 16'd3, 16'd4, 5'h02, now);
    send_pkt(cft_pkg::ETYPE_VLAN_C, cft_pkg::ETYPE_IPV4,
             16'(cft_pkg::HDR_LEN_TAGGED - 16'd1), cft_pkg::PROTO_TCP, 32'd1, 32'd2,
             16'd3, 16'd4, 5'h02, now);
    send_pkt(cft_pkg::ETYPE_VLAN_S, 16'h86DD, 16'hFFFF, cft_pkg::PROTO_TCP, 32'd1, 32'd2,
             16'd3, 16'd4, 5'h02, now);
    // unknown non-SYN, then a full open and close at the field extremes
    send_pkt(cft_pkg::ETYPE_IPV4, 16'h0, cft_pkg::HDR_LEN_PLAIN, cft_pkg::PROTO_TCP,
             32'hFFFFFFFF, 32'd0, 16'hFFFF, 16'd0, 5'h10, now);
    send_pkt(cft_pkg::ETYPE_VLAN_C, cft_pkg::ETYPE_IPV4, cft_pkg::HDR_LEN_TAGGED,
             cft_pkg::PROTO_TCP, 32'hFFFFFFFF, 32'd0, 16'hFFFF, 16'd0, 5'h02, now);
    send_pkt(cft_pkg::ETYPE_IPV4, 16'h0, cft_pkg::HDR_LEN_PLAIN, cft_pkg::PROTO_TCP,
             32'd0, 32'hFFFFFFFF, 16'd0, 16'hFFFF, 5'h12, now);
    for (int i = 1; i < 7; i++)
      send_tcp(32'd0, 32'hFFFFFFFF, 16'd0, 16'hFFFF, close_seq[i]);
    // bad flags in established, then reset close
    send_tcp(32'd5, 32'd6, 16'd7, 16'd8, 5'h02);
    send_tcp(32'd6, 32'd5, 16'd8, 16'd7, 5'h10);
    send_tcp(32'd5, 32'd6, 16'd7, 16'd8, 5'h02);
    send_tcp(32'd5, 32'd6, 16'd7, 16'd8, 5'h04);
    send_tcp(32'd5, 32'd6, 16'd7, 16'd8, 5'h10);
    send_tcp(32'd9, 32'd9, 16'd1, 16'd1, 5'h1F);

    new_flows();
    run_traffic(280, 5);

    set_timeout(64'd0);
    new_flows();
    hold_req = 1'b1;
    run_traffic(280, 2);

    set_timeout(64'hFFFFFFFFFFFFFFFF);
    for (int i = 0; i < 70; i++) send_tcp($urandom, $urandom, 16'(i), 16'd443, 5'h02);
    new_flows();
    run_traffic(220, 1000);

    set_timeout(64'd3);
    new_flows();
    now = 64'hFFFFFFFFFFFFFF00;
    run_traffic(320, 2);

    set_timeout({$urandom, $urandom});
    new_flows();
    run_traffic(300, 100000);

    set_timeout(64'd40);
    new_flows();
    quiet = 1'b1;
    run_traffic(300, 8);

    in_push <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN) @(posedge clk);
    $display("Sent %0d packets under %0d timeout settings, %0d verdicts checked.",
             packets_sent, settings_used, checked);
    $display("Covered tagged and short frames, full table, expiry, resets and closes.");
    if (fail_count == 0) begin
      $display("[tcp_conntrack_firewall_top] OK");
    end else begin
      $display("[tcp_conntrack_firewall_top] ERROR");
    end
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/cft_pkg.sv
rtl/cft_queue.sv
rtl/cft_front.sv
rtl/cft_back.sv
rtl/tcp_conntrack_firewall_top.sv
tb/conntrack_checker.sv
tb/tb_top.sv
